// ===== rtl/cellular_crack_height_defines.svh =====
// ---------------------------------------------------------------------------
// Cellular crack height assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef CELLULAR_CRACK_HEIGHT_DEFINES_SVH
`define CELLULAR_CRACK_HEIGHT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCH_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CCH_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define CCH_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== rtl/cch_pkg.sv =====
// ---------------------------------------------------------------------------
// Cellular crack height package
// Constants, register indexes and the square root stage type.
// ---------------------------------------------------------------------------
package cch_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam logic [1:0] REG_SEED       = 2'd0;
  localparam logic [1:0] REG_CELL_SCALE = 2'd1;
  localparam logic [1:0] REG_STRENGTH   = 2'd2;

  localparam logic [31:0] SEED_RST     = 32'd1337;
  localparam logic [18:0] SCALE_RST    = 19'd14336;
  localparam logic [15:0] STRENGTH_RST = 16'd9830;

  localparam logic [31:0] HASH_CX   = 32'h9e3779b9;
  localparam logic [31:0] HASH_CY   = 32'h85ebca6b;
  localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;
  localparam logic [31:0] SEED_Y_OFS = 32'd37;

  localparam logic [15:0] JIT_OFFSET = 16'd3277;
  localparam logic [15:0] JIT_SCALE  = 16'd58982;

  localparam int SQ_IN_W   = 36;
  localparam int SQ_ROOT_W = 18;
  localparam int SQ_REM_W  = 20;
  localparam int SQ_STEPS_PER_STAGE = 3;
  localparam int SQ_STAGES = SQ_ROOT_W / SQ_STEPS_PER_STAGE;

  typedef struct packed {
    logic [SQ_IN_W-1:0]   rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } cch_sqrt_t;

endpackage

// ===== rtl/cch_sqrt_stage.sv =====
// ---------------------------------------------------------------------------
// Cellular crack height square root stage
// Registered digit-by-digit integer square root, a few result bits per stage.
// ---------------------------------------------------------------------------
module cch_sqrt_stage import cch_pkg::*; #(
  parameter int STEPS = SQ_STEPS_PER_STAGE
) (
  input  logic      clk,
  input  logic      en,
  input  cch_sqrt_t din,
  output cch_sqrt_t dout
);

  cch_sqrt_t s_next;

  always_comb begin
    logic [SQ_REM_W+1:0] tmp;
    logic [SQ_REM_W+1:0] trial;
    s_next = din;
    for (int i = 0; i < STEPS; i++) begin
      tmp = {s_next.rem, s_next.rad[SQ_IN_W-1 -: 2]};
      trial = {(SQ_REM_W+2-SQ_ROOT_W-2)'(0), s_next.root, 2'b01};
      s_next.rad = {s_next.rad[SQ_IN_W-3:0], 2'b00};
      if (tmp >= trial) begin
        s_next.rem = SQ_REM_W'(tmp - trial);
        s_next.root = {s_next.root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        s_next.rem = tmp[SQ_REM_W-1:0];
        s_next.root = {s_next.root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= s_next;
    end
  end

endmodule

// ===== rtl/cellular_crack_height.sv =====
// ---------------------------------------------------------------------------
// Cellular crack height
// Worley F2 minus F1 crack relief applied to a terrain height, per pixel.
// ---------------------------------------------------------------------------
// The block accepts one pixel per clock unless the output stalls and returns
// each result through a fully pipelined datapath: position multiply, four hash
// multiply stages for the nine neighbor cells, distance squares, a two-stage
// nearest-pair selection, two six-stage square roots and the smoothstep and
// weighting multiplies. A stall on the output freezes the whole pipeline, so
// the input is ready whenever the output register is empty or being taken.
module cellular_crack_height import cch_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [16:0]        coord_u,
  input  logic [16:0]        coord_v,
  input  logic signed [15:0] base_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        edge_distance,
  output logic signed [15:0] cracked_height
);

  localparam int SH = COORD_FRAC_BITS + 10 - 16;
  localparam int PW = 36 - SH;
  localparam int NS = 22;

  logic [31:0] seed;
  logic [18:0] cell_scale;
  logic [15:0] strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RST;
      cell_scale <= SCALE_RST;
      strength <= STRENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEED:       seed <= cfg_data;
        REG_CELL_SCALE: cell_scale <= cfg_data[18:0];
        REG_STRENGTH:   strength <= cfg_data[15:0];
        default:        ;
      endcase
    end
  end

  logic en;
  logic [NS:1] vld;
  logic signed [15:0] bp [1:NS];

  assign en = !vld[NS] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bp[1] <= base_height;
      for (int i = 2; i <= NS; i++) begin
        bp[i] <= bp[i-1];
      end
    end
  end

  // Stage 1: scaled position.
  logic [35:0] prod_u, prod_v;
  logic [PW-1:0] pu1, pv1;
  assign prod_u = 36'(coord_u) * 36'(cell_scale);
  assign prod_v = 36'(coord_v) * 36'(cell_scale);

  always_ff @(posedge clk) begin
    if (en) begin
      pu1 <= prod_u[35:SH];
      pv1 <= prod_v[35:SH];
    end
  end

  // Stage 2: cell coordinate products.
  logic [31:0] cx2 [3], cy2 [3];
  logic [31:0] max2 [3], mbx2 [3], may2 [3], mby2 [3];
  logic [15:0] fxp [2:6], fyp [2:6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx2[i] = (32'(pu1[PW-1:16]) + 32'(i)) - 32'd1;
      cy2[i] = (32'(pv1[PW-1:16]) + 32'(i)) - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        max2[i] <= cx2[i] * HASH_CX;
        mbx2[i] <= cx2[i] * HASH_CY;
        may2[i] <= cy2[i] * HASH_CX;
        mby2[i] <= cy2[i] * HASH_CY;
      end
      fxp[2] <= pu1[15:0];
      fyp[2] <= pv1[15:0];
      for (int i = 3; i <= 6; i++) begin
        fxp[i] <= fxp[i-1];
        fyp[i] <= fyp[i-1];
      end
    end
  end

  // Stages 3 to 5: hash mixing and jitter.
  logic [31:0] seed_y;
  logic [31:0] hx3 [9], hy3 [9], hx4 [9], hy4 [9];
  logic [15:0] jx5 [9], jy5 [9];
  assign seed_y = seed + SEED_Y_OFS;

  always_ff @(posedge clk) begin
    logic [31:0] ax, ay;
    logic [39:0] fx, fy;
    if (en) begin
      for (int iy = 0; iy < 3; iy++) begin
        for (int ix = 0; ix < 3; ix++) begin
          ax = max2[ix] ^ mby2[iy] ^ seed;
          ay = may2[iy] ^ mbx2[ix] ^ seed_y;
          hx3[iy*3+ix] <= (ax ^ (ax >> 16)) * MIX_MUL_A;
          hy3[iy*3+ix] <= (ay ^ (ay >> 16)) * MIX_MUL_A;
        end
      end
      for (int k = 0; k < 9; k++) begin
        hx4[k] <= (hx3[k] ^ (hx3[k] >> 15)) * MIX_MUL_B;
        hy4[k] <= (hy3[k] ^ (hy3[k] >> 15)) * MIX_MUL_B;
        ax = hx4[k] ^ (hx4[k] >> 16);
        ay = hy4[k] ^ (hy4[k] >> 16);
        fx = 40'(ax[23:0]) * 40'(JIT_SCALE) + 40'h0000800000;
        fy = 40'(ay[23:0]) * 40'(JIT_SCALE) + 40'h0000800000;
        jx5[k] <= fx[39:24] + JIT_OFFSET;
        jy5[k] <= fy[39:24] + JIT_OFFSET;
      end
    end
  end

  // Stages 6 and 7: squared distances.
  logic [34:0] sqx6 [9], sqy6 [9];
  logic [35:0] d7 [9];

  always_ff @(posedge clk) begin
    logic signed [18:0] ex, ey;
    logic signed [37:0] px, py;
    if (en) begin
      for (int iy = 0; iy < 3; iy++) begin
        for (int ix = 0; ix < 3; ix++) begin
          ex = $signed({3'b000, fxp[5]}) - $signed(19'(ix) - 19'sd1) * 19'sd65536
               - $signed({3'b000, jx5[iy*3+ix]});
          ey = $signed({3'b000, fyp[5]}) - $signed(19'(iy) - 19'sd1) * 19'sd65536
               - $signed({3'b000, jy5[iy*3+ix]});
          px = ex * ex;
          py = ey * ey;
          sqx6[iy*3+ix] <= px[34:0];
          sqy6[iy*3+ix] <= py[34:0];
        end
      end
      for (int k = 0; k < 9; k++) begin
        d7[k] <= 36'(sqx6[k]) + 36'(sqy6[k]);
      end
    end
  end

  // Stages 8 and 9: two smallest distances.
  logic [35:0] m1_8, m2_8, m1_9, m2_9;
  logic [35:0] rest8 [4];
  logic [35:0] m1_a, m2_a, m1_b, m2_b;

  always_comb begin
    m1_a = '1;
    m2_a = '1;
    for (int k = 0; k < 5; k++) begin
      if (d7[k] < m1_a) begin
        m2_a = m1_a;
        m1_a = d7[k];
      end else if (d7[k] < m2_a) begin
        m2_a = d7[k];
      end
    end
    m1_b = m1_8;
    m2_b = m2_8;
    for (int k = 0; k < 4; k++) begin
      if (rest8[k] < m1_b) begin
        m2_b = m1_b;
        m1_b = rest8[k];
      end else if (rest8[k] < m2_b) begin
        m2_b = rest8[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_8 <= m1_a;
      m2_8 <= m2_a;
      for (int k = 0; k < 4; k++) begin
        rest8[k] <= d7[k+5];
      end
      m1_9 <= m1_b;
      m2_9 <= m2_b;
    end
  end

  // Stages 10 to 15: square roots of both distances.
  cch_sqrt_t sq_a [SQ_STAGES+1];
  cch_sqrt_t sq_b [SQ_STAGES+1];

  assign sq_a[0] = '{rad: m1_9, rem: '0, root: '0};
  assign sq_b[0] = '{rad: m2_9, rem: '0, root: '0};

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    cch_sqrt_stage #(.STEPS(SQ_STEPS_PER_STAGE)) u_sqrt_a (
      .clk(clk), .en(en), .din(sq_a[j]), .dout(sq_a[j+1])
    );
    cch_sqrt_stage #(.STEPS(SQ_STEPS_PER_STAGE)) u_sqrt_b (
      .clk(clk), .en(en), .din(sq_b[j]), .dout(sq_b[j+1])
    );
  end

  // Stages 16 to 22: edge, smoothstep, weighting and saturation.
  logic [SQ_ROOT_W-1:0] diff;
  logic [15:0] edge_c;
  logic [19:0] t9;
  logic [15:0] ep [16:NS];
  logic [16:0] t16;
  logic [33:0] tt17;
  logic [17:0] w17;
  logic [51:0] s_prod;
  logic [16:0] crack18;
  logic [32:0] cs19;
  logic [35:0] y_sum;
  logic [20:0] y20, y21;
  logic [33:0] q_prod;
  logic [16:0] q0_21;
  logic [21:0] q25;
  logic [16:0] q;
  logic signed [17:0] r;
  logic signed [15:0] r_sat;

  assign diff = sq_b[SQ_STAGES].root - sq_a[SQ_STAGES].root;
  assign edge_c = (diff > SQ_ROOT_W'(16'hffff)) ? 16'hffff : diff[15:0];
  assign t9 = 20'(edge_c) * 20'd9;
  assign s_prod = 52'(tt17) * 52'(w17);
  assign y_sum = {1'b0, cs19, 2'b00} + 36'd409600;
  assign q_prod = 34'(y20) * 34'd5243;
  assign q25 = 22'(q0_21) * 22'd25;
  assign q = (q25 > 22'(y21)) ? q0_21 - 17'd1 : q0_21;
  assign r = 18'(bp[NS-1]) - $signed({1'b0, q});

  always_comb begin
    if (r > 18'sd32767) begin
      r_sat = 16'sh7fff;
    end else if (r < -18'sd32768) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ep[16] <= edge_c;
      for (int i = 17; i <= NS; i++) begin
        ep[i] <= ep[i-1];
      end
      t16 <= (t9 > 20'd65536) ? 17'd65536 : t9[16:0];
      tt17 <= 34'(t16) * 34'(t16);
      w17 <= 18'd196608 - {t16, 1'b0};
      crack18 <= 17'(18'd65536 - 18'(s_prod[51:32]));
      cs19 <= 33'(crack18) * 33'(strength);
      y20 <= y_sum[35:15];
      y21 <= y20;
      q0_21 <= q_prod[33:17];
      cracked_height <= r_sat;
    end
  end

  assign edge_distance = ep[NS];

endmodule

// ===== rtl/cch_checker.sv =====
// ---------------------------------------------------------------------------
// Cellular crack height checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "cellular_crack_height_defines.svh"

module cch_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] edge_distance,
  input logic [15:0] cracked_height
);

  `CCH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `CCH_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(edge_distance) && $stable(cracked_height))
  `CCH_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)
  `CCH_ASSERT_IMPL(a_flow, clk, rst, !out_valid || out_ready, in_ready)

endmodule

bind cellular_crack_height cch_checker u_cch_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .edge_distance(edge_distance),
  .cracked_height(cracked_height)
);

// ===== dv/cellular_crack_height_checker.sv =====
// ---------------------------------------------------------------------------
// Cellular crack height checker
// Watches both channels, predicts each pixel result and compares it.
// ---------------------------------------------------------------------------
module cellular_crack_height_checker import cch_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [16:0]        coord_u,
  input  logic [16:0]        coord_v,
  input  logic signed [15:0] base_height,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        edge_distance,
  input  logic signed [15:0] cracked_height,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] edge_d;
    logic [15:0] height;
  } pixel_t;

  logic [31:0] seed_r;
  logic [18:0] scale_r;
  logic [15:0] strength_r;
  pixel_t expected_pixels[$];

  function automatic logic [31:0] mix(logic [31:0] x);
    x = x ^ (x >> 16);
    x = x * MIX_MUL_A;
    x = x ^ (x >> 15);
    x = x * MIX_MUL_B;
    x = x ^ (x >> 16);
    return x;
  endfunction

  function automatic longint cell_jitter(logic [31:0] a, logic [31:0] b, logic [31:0] s);
    logic [31:0] h;
    logic [63:0] f;
    h = mix((a * HASH_CX) ^ (b * HASH_CY) ^ s);
    f = {40'd0, h[23:0]};
    return 3277 + longint'((f * 64'd58982 + (64'd1 << 23)) >> 24);
  endfunction

  function automatic longint floor_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic pixel_t crack_pixel(logic [16:0] u, logic [16:0] v,
                                         logic signed [15:0] base);
    logic [63:0] px, py, d, d1, d2, t, s, crack, depth;
    longint bx, by, fx, fy, ex, ey, edge_v, r;
    logic [31:0] cx, cy;
    pixel_t p;
    px = (64'(u) * 64'(scale_r)) >> (COORD_FRAC_BITS_DEF - 6);
    py = (64'(v) * 64'(scale_r)) >> (COORD_FRAC_BITS_DEF - 6);
    bx = longint'(px >> 16);
    by = longint'(py >> 16);
    fx = longint'(px & 64'hFFFF);
    fy = longint'(py & 64'hFFFF);
    d1 = '1;
    d2 = '1;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        cx = 32'(bx + dx);
        cy = 32'(by + dy);
        ex = fx - longint'(dx) * 65536 - cell_jitter(cx, cy, seed_r);
        ey = fy - longint'(dy) * 65536 - cell_jitter(cy, cx, seed_r + SEED_Y_OFS);
        d = 64'(ex * ex) + 64'(ey * ey);
        if (d < d1) begin
          d2 = d1;
          d1 = d;
        end else if (d < d2) begin
          d2 = d;
        end
      end
    end
    edge_v = floor_sqrt(d2) - floor_sqrt(d1);
    if (edge_v > 65535) edge_v = 65535;
    t = 64'(edge_v) * 9;
    if (t > 65536) t = 65536;
    s = (t * t * (64'd196608 - 2 * t)) >> 32;
    crack = 65536 - s;
    depth = (crack * 64'(strength_r) * 4 + 64'd409600) / 64'd819200;
    r = longint'(base) - longint'(depth);
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    p.edge_d = 16'(edge_v);
    p.height = 16'(r);
    return p;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      seed_r <= SEED_RST;
      scale_r <= SCALE_RST;
      strength_r <= STRENGTH_RST;
      expected_pixels.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SEED: seed_r <= cfg_data;
          REG_CELL_SCALE: scale_r <= cfg_data[18:0];
          REG_STRENGTH: strength_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(crack_pixel(coord_u, coord_v, base_height));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transaction edge=%0d height=%0d", $time,
                   edge_distance, cracked_height);
          errors <= errors + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (e.edge_d !== edge_distance || e.height !== cracked_height) begin
            $display("%0t: mismatch expected edge=%0d height=%0d actual edge=%0d height=%0d",
                     $time, e.edge_d, $signed(e.height), edge_distance, cracked_height);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/cellular_crack_height_tb.sv =====
// ---------------------------------------------------------------------------
// Cellular crack height testbench
// Drives directed and random pixels through several register settings with
// random gaps and output stalls; a checker module predicts and compares.
// ---------------------------------------------------------------------------
module cellular_crack_height_tb import cch_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst, cfg_write, in_valid, in_ready, out_valid, out_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic [16:0] coord_u, coord_v;
  logic signed [15:0] base_height, cracked_height;
  logic [15:0] edge_distance;
  int errors, pending;
  bit stall_free;

  cellular_crack_height uut (.*);
  cellular_crack_height_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_ready = 0;
    @(negedge clk);
    forever begin
      int w;
      w = stall_free ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_pixel(logic [16:0] u, logic [16:0] v, logic [15:0] b, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 13) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(negedge clk);
    end
    in_valid <= 1;
    coord_u <= u;
    coord_v <= v;
    base_height <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    @(negedge clk);
  endtask

  task automatic random_pixels(int n);
    logic [16:0] u, v;
    for (int i = 0; i < n; i++) begin
      stall_free = (i % 150) < 20;
      u = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      v = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      send_pixel(u, v, 16'($urandom), !stall_free);
    end
    stall_free = 0;
  endtask

  initial begin
    logic [15:0] bases[4];
    rst = 1;
    cfg_write = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    coord_u = 0;
    coord_v = 0;
    base_height = 0;
    stall_free = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    bases = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    for (int i = 0; i < 16; i++)
      send_pixel((i & 1) ? 17'h1ffff : ((i & 2) ? 17'd65536 : 17'd0),
                 (i & 4) ? 17'h1ffff : ((i & 8) ? 17'd65536 : 17'd0),
                 bases[i % 4], 1);
    send_pixel(17'd32768, 17'd32768, 16'h1234, 1);
    drain();
    random_pixels(300);
    drain();
    write_reg(REG_SEED, 32'h8000_0000);
    write_reg(REG_CELL_SCALE, 32'd0);
    write_reg(REG_STRENGTH, 32'd32768);
    write_reg(2'd3, 32'hffff_ffff);
    send_pixel(17'd100, 17'd65536, 16'h8000, 1);
    send_pixel(17'h1ffff, 17'd0, 16'h7fff, 1);
    random_pixels(100);
    drain();
    write_reg(REG_SEED, 32'h7fff_ffff);
    write_reg(REG_CELL_SCALE, 32'h7ffff);
    write_reg(REG_STRENGTH, 32'd0);
    random_pixels(200);
    drain();
    write_reg(REG_SEED, 32'hffff_ffff);
    write_reg(REG_CELL_SCALE, 32'd1024);
    write_reg(REG_STRENGTH, 32'hffff);
    random_pixels(200);
    drain();
    write_reg(REG_SEED, $urandom);
    write_reg(REG_CELL_SCALE, $urandom_range(0, 524287));
    write_reg(REG_STRENGTH, $urandom_range(0, 32768));
    random_pixels(300);
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
